>>> hw/rtl/esravg_pkg.sv
`default_nettype none

package esravg_pkg;

  localparam int SAMPLES_PER_AVERAGE_DEF = 64;
  localparam int ADC_BITS_DEF            = 10;

  localparam int QUEUE_DEPTH = 2;

  // Output resistance scale: 499*10/(499+10)*100, truncated
  localparam int ESR_R_OUT    = 980;
  localparam int ESR_MAX      = 32767;
  localparam int ESR_OVERLOAD = 9999;
  localparam int ZERO_LIMIT   = 200;

  localparam int ESR_W       = 16;
  localparam int OFFSET_W    = 8;
  localparam int KIND_W      = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ZERO   = 1'b1
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEAS     = 2'd0,
    KIND_ZERO_OK  = 2'd1,
    KIND_ZERO_REJ = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } bstate_e;

endpackage

`default_nettype wire

>>> hw/rtl/esravg_front.sv
`default_nettype none

module esravg_front import esravg_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int ADC_BITS            = ADC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire opcode_e             opcode_i,
  input  wire logic [ADC_BITS-1:0] sample_i,
  output logic                     push_o,
  output logic [ADC_BITS:0]        job_o,     // {is_zero_request, average}
  input  wire logic                full_i
);

  localparam int SUM_W  = ADC_BITS + 6;
  localparam int CNT_W  = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int K      = SUM_W + 6;
  localparam int PROD_W = SUM_W + K + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);

  logic [SUM_W-1:0]    sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADC_BITS-1:0] avg_q, avg_d, avg_new;
  logic [PROD_W-1:0]   prod;
  logic                accept, last;

  assign ready_o  = !full_i;
  assign accept   = valid_i && ready_o;
  assign sum_next = sum_q + SUM_W'(sample_i);
  assign last     = (cnt_q == CNT_W'(SAMPLES_PER_AVERAGE - 1));

  // Divide by the block length as a multiply by its scaled reciprocal
  assign prod    = PROD_W'(sum_next) * PROD_W'(RECIP);
  assign avg_new = prod[K +: ADC_BITS];

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    avg_d  = avg_q;
    push_o = 1'b0;
    job_o  = {1'b1, avg_q};
    if (accept) begin
      if (opcode_i == OP_ZERO) begin
        push_o = 1'b1;
      end else if (last) begin
        push_o = 1'b1;
        job_o  = {1'b0, avg_new};
        avg_d  = avg_new;
        sum_d  = '0;
        cnt_d  = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      avg_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      avg_q <= avg_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/esravg_fifo.sv
`default_nettype none

module esravg_fifo import esravg_pkg::*; #(
  parameter int W     = ADC_BITS_DEF + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/esravg_back.sv
`default_nettype none

module esravg_back import esravg_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ADC_BITS-1:0] open_i,
  input  wire logic                empty_i,
  input  wire logic [ADC_BITS:0]   job_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output kind_e                    kind_o,
  output logic [ESR_W-1:0]         esr_o,
  output logic                     overload_o
);

  localparam int NUM_W = ADC_BITS + 10;
  localparam int CNT_W = $clog2(NUM_W);

  bstate_e             state_q, state_d;
  logic                zero_q, zero_d;
  logic                sat_q, sat_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [ADC_BITS-1:0] rem_q, rem_d;
  logic [ADC_BITS-1:0] div_q, div_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [ESR_W-1:0]    out_esr_q, out_esr_d;
  logic                out_ovl_q, out_ovl_d;

  logic [ADC_BITS-1:0] job_avg;
  logic [ADC_BITS:0]   shifted, trial;
  logic                qbit;
  logic [OFFSET_W-1:0] off_sel;
  logic signed [NUM_W:0] corr;
  logic [ESR_W-1:0]    esr;
  logic                reject;

  assign job_avg = job_i[ADC_BITS-1:0];

  // One restoring division step
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign qbit    = !trial[ADC_BITS];

  // Subtract offset (none for a zero request), saturate at the top of the signed 16-bit range
  assign off_sel = zero_q ? '0 : offset_q;
  assign corr    = $signed({1'b0, num_q}) - $signed((NUM_W + 1)'(off_sel));
  always_comb begin
    if (sat_q || (corr > $signed((NUM_W + 1)'(ESR_MAX)))) begin
      esr = ESR_W'(ESR_MAX);
    end else begin
      esr = corr[ESR_W-1:0];
    end
  end
  assign reject = $signed(esr) > $signed(ESR_W'(ZERO_LIMIT));

  always_comb begin
    state_d     = state_q;
    zero_d      = zero_q;
    sat_d       = sat_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    offset_d    = offset_q;
    out_valid_d = out_valid_q && !ready_i;
    out_kind_d  = out_kind_q;
    out_esr_d   = out_esr_q;
    out_ovl_d   = out_ovl_q;
    pop_o       = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          zero_d = job_i[ADC_BITS];
          num_d  = NUM_W'(job_avg) * NUM_W'(ESR_R_OUT);
          rem_d  = '0;
          div_d  = open_i - job_avg;
          cnt_d  = '0;
          if (job_avg >= open_i) begin
            sat_d   = 1'b1;
            state_d = B_DONE;
          end else begin
            sat_d   = 1'b0;
            state_d = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_d = qbit ? trial[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
        num_d = {num_q[NUM_W-2:0], qbit};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        // Hold the result until the output register frees up
        if (!out_valid_q || ready_i) begin
          out_valid_d = 1'b1;
          out_esr_d   = esr;
          out_ovl_d   = $signed(esr) > $signed(ESR_W'(ESR_OVERLOAD));
          if (!zero_q) begin
            out_kind_d = KIND_MEAS;
          end else if (reject) begin
            out_kind_d = KIND_ZERO_REJ;
          end else begin
            out_kind_d = KIND_ZERO_OK;
            offset_d   = esr[OFFSET_W-1:0];
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q     <= zero_d;
    sat_q      <= sat_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    cnt_q      <= cnt_d;
    out_kind_q <= out_kind_d;
    out_esr_q  <= out_esr_d;
    out_ovl_q  <= out_ovl_d;
  end

  assign valid_o    = out_valid_q;
  assign kind_o     = out_kind_q;
  assign esr_o      = out_esr_q;
  assign overload_o = out_ovl_q;

endmodule

`default_nettype wire

>>> hw/rtl/esr_averaging_calculator.sv
// ESR averaging calculator.
// Input stream (s_axis_*): one transaction per probe ADC sample (tuser = 0) or
// per zero calibration request (tuser = 1). Samples are summed; every
// SAMPLES_PER_AVERAGE samples the average is formed and one measurement result
// follows on the output stream (m_axis_*). A calibration request always gives
// one result: zero accepted (offset stored) or zero rejected.
// cfg_we_i/cfg_wdata_i write the open-probe reading; write only while idle.
// Throughput: the front end takes one transaction per cycle while its two-entry
// job queue has room. The back end takes one job at a time, through a load step,
// the bit-serial divider (one quotient bit per cycle, ADC_BITS + 10 bits) and a
// finish step; a job that saturates skips the divider.
// When the receiver stalls, the result sits in the output register, the back
// end holds its next finished job, and the queue fills; s_axis_tready then
// drops. Reset clears the sum, count, latest average and zero offset, and sets
// the open-probe reading to 1023 (all ones for the default ADC_BITS).
`default_nettype none

module esr_averaging_calculator import esravg_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int ADC_BITS            = ADC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: adc_sample [ADC_BITS-1:0], zero fill above
  input  wire logic [((ADC_BITS + 7) / 8)*8-1:0] s_axis_tdata,
  // tuser: opcode [0]
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: esr_value [15:0], overload [16], zero fill above
  output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
  // tuser: result_kind [1:0]
  output logic [KIND_W-1:0]                      m_axis_tuser,
  input  wire logic                              cfg_we_i,
  input  wire logic [ADC_BITS-1:0]               cfg_wdata_i
);

  localparam int JOB_W = ADC_BITS + 1;

  logic [ADC_BITS-1:0] open_q;
  logic                push, full, pop, empty;
  logic [JOB_W-1:0]    job_in, job_out;
  kind_e               kind;
  logic [ESR_W-1:0]    esr;
  logic                overload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= ADC_BITS'(1023);
    end else if (cfg_we_i) begin
      open_q <= cfg_wdata_i;
    end
  end

  esravg_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
    .ADC_BITS           (ADC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .opcode_i(opcode_e'(s_axis_tuser)),
    .sample_i(s_axis_tdata[ADC_BITS-1:0]),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full)
  );

  esravg_fifo #(
    .W    (JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(empty)
  );

  esravg_back #(
    .ADC_BITS(ADC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .open_i    (open_q),
    .empty_i   (empty),
    .job_i     (job_out),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .kind_o    (kind),
    .esr_o     (esr),
    .overload_o(overload)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - ESR_W - 1)'(0), overload, esr};
  assign m_axis_tuser = kind;

endmodule

`default_nettype wire

>>> hw/rtl/esravg_checker.sv
`default_nettype none

module esravg_checker import esravg_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [KIND_W-1:0]      m_axis_tuser
);

  logic signed [ESR_W-1:0] esr;
  assign esr = $signed(m_axis_tdata[ESR_W-1:0]);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_overload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ESR_W] == (esr > $signed(ESR_W'(ESR_OVERLOAD))))
    else $error("overload flag does not match value");

  a_zero_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ZERO_OK |->
      esr >= 0 && esr <= $signed(ESR_W'(ZERO_LIMIT)))
    else $error("accepted zero out of range");

  a_zero_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ZERO_REJ |->
      esr > $signed(ESR_W'(ZERO_LIMIT)))
    else $error("rejected zero within range");

endmodule

bind esr_averaging_calculator esravg_checker u_esravg_checker (.*);

`default_nettype wire

>>> bench/tb_esr_averaging_calculator.sv
`default_nettype none

module tb_esr_averaging_calculator;
  timeunit 1ns;
  timeprecision 1ps;

  import esravg_pkg::*;

  localparam int ADC_W        = ADC_BITS_DEF;
  localparam int IN_TDATA_W   = ((ADC_W + 7) / 8) * 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20000;
  localparam int SETTLE       = 60;
  localparam int MEAS_PER_RUN = 2;
  localparam int PLAN_ROWS    = 8;

  typedef struct packed {
    kind_e             kind;
    logic [ESR_W-1:0]  esr;
    logic              ovl;
  } reading_t;

  typedef struct {
    opcode_e           op;
    logic [ADC_W-1:0]  smp;
    int                reps;
    bit                typed;
    reading_t          want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [ADC_W-1:0]      cfg_wdata_i = '0;

  esr_averaging_calculator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block state
  logic [ADC_W+5:0]   acc_sum    = '0;
  int                 acc_count  = 0;
  logic [ADC_W-1:0]   last_avg   = '0;
  logic [OFFSET_W-1:0] zero_ofs  = '0;
  logic [ADC_W-1:0]   open_level = '1;

  reading_t pending_readings[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       rx_hold_len = 0;
  int       rx_hold_reqs = 0;
  int       rx_hold_seen = 0;
  int       rx_hold_left = 0;

  function automatic int esr_hundredths(int avg, int open_v, int ofs);
    int r;
    if (avg >= open_v) return ESR_MAX;
    r = (ESR_R_OUT * avg) / (open_v - avg) - ofs;
    if (r > ESR_MAX) r = ESR_MAX;
    return r;
  endfunction

  function automatic reading_t make_reading(kind_e kind, int esr);
    reading_t rd;
    rd.kind = kind;
    rd.esr  = esr[ESR_W-1:0];
    rd.ovl  = (esr > ESR_OVERLOAD);
    return rd;
  endfunction

  // Advance the shadow state by one accepted transaction; return 1 when a reading follows.
  function automatic bit advance_probe(input opcode_e op, input logic [ADC_W-1:0] smp,
                                       output reading_t rd);
    int z;
    rd = '0;
    if (op == OP_ZERO) begin
      z = esr_hundredths(int'(last_avg), int'(open_level), 0);
      if (z > ZERO_LIMIT) begin
        rd = make_reading(KIND_ZERO_REJ, z);
      end else begin
        zero_ofs = z[OFFSET_W-1:0];
        rd = make_reading(KIND_ZERO_OK, z);
      end
      return 1'b1;
    end
    acc_sum = acc_sum + smp;
    acc_count++;
    if (acc_count < SAMPLES_PER_AVERAGE_DEF) return 1'b0;
    last_avg  = ADC_W'(acc_sum / SAMPLES_PER_AVERAGE_DEF);
    acc_sum   = '0;
    acc_count = 0;
    z = esr_hundredths(int'(last_avg), int'(open_level), int'(zero_ofs));
    rd = make_reading(KIND_MEAS, z);
    return 1'b1;
  endfunction

  task automatic send_item(input opcode_e op, input logic [ADC_W-1:0] smp);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(smp);
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send one transaction and queue what it should produce.
  task automatic feed_probe(input opcode_e op, input logic [ADC_W-1:0] smp,
                            input bit typed, input reading_t typed_rd, output bit produced,
                            output kind_e kind);
    reading_t rd;
    send_item(op, smp);
    produced = advance_probe(op, smp, rd);
    kind = rd.kind;
    if (produced) pending_readings.push_back(typed ? typed_rd : rd);
  endtask

  task automatic drain_readings();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    // let any job still in the back end settle
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_open_level(input logic [ADC_W-1:0] level);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= level;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    open_level = level;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    plan_row_t plan [PLAN_ROWS];
    bit    produced;
    kind_e kind;
    plan = '{
      '{OP_ZERO,   10'd0,    1,  1'b1, make_reading(KIND_ZERO_OK, 0)},
      '{OP_SAMPLE, 10'd1023, 64, 1'b1, make_reading(KIND_MEAS, ESR_MAX)},
      '{OP_ZERO,   10'd1023, 1,  1'b1, make_reading(KIND_ZERO_REJ, ESR_MAX)},
      '{OP_SAMPLE, 10'd174,  32, 1'b0, '0},
      // calibration in mid-block: sample field ignored, count kept
      '{OP_ZERO,   10'd1023, 1,  1'b1, make_reading(KIND_ZERO_REJ, ESR_MAX)},
      '{OP_SAMPLE, 10'd174,  32, 1'b0, '0},
      '{OP_ZERO,   10'd0,    1,  1'b0, '0},
      '{OP_SAMPLE, 10'd960,  64, 1'b0, '0}
    };
    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        feed_probe(plan[i].op, plan[i].smp, plan[i].typed, plan[i].want, produced, kind);
      end
    end
  endtask

  task automatic run_random(input int tx_pct, input int rx_pct, input int hold,
                            input bit pause_midway);
    int    meas_seen;
    int    style;
    int    base;
    int    v;
    bit    paused;
    bit    produced;
    kind_e kind;
    opcode_e op;
    meas_seen = 0;
    style = 0;
    base = 0;
    paused = 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold > 0) begin
      rx_hold_len = hold;
      rx_hold_reqs++;
    end
    while (meas_seen < MEAS_PER_RUN) begin
      if (acc_count == 0) begin
        style = $urandom_range(0, 3);
        case (style)
          1:       base = $urandom_range(0, 220);
          2:       base = int'(open_level);
          default: base = $urandom_range(0, 1023);
        endcase
      end
      if (style == 0) v = $urandom_range(0, 1023);
      else            v = base + $urandom_range(0, 12) - 6;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      op = ($urandom_range(0, 15) == 0) ? OP_ZERO : OP_SAMPLE;
      if (op == OP_ZERO) v = $urandom_range(0, 1023);
      feed_probe(op, v[ADC_W-1:0], 1'b0, '0, produced, kind);
      if (produced && kind == KIND_MEAS) meas_seen++;
      if (pause_midway && !paused && meas_seen == MEAS_PER_RUN / 2) begin
        // hold the sender until every reading is back
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: random back-pressure, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = rx_hold_len;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    reading_t seen;
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind = kind_e'(m_axis_tuser);
      seen.esr  = m_axis_tdata[ESR_W-1:0];
      seen.ovl  = m_axis_tdata[ESR_W];
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: kind=%0d esr=%0d ovl=%0b",
                   seen.kind, $signed(seen.esr), seen.ovl);
      end else begin
        want = pending_readings.pop_front();
        if (seen.kind !== want.kind || seen.esr !== want.esr || seen.ovl !== want.ovl) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"reading mismatch: expected kind=%0d esr=%0d ovl=%0b,",
                      " got kind=%0d esr=%0d ovl=%0b"},
                     want.kind, $signed(want.esr), want.ovl,
                     seen.kind, $signed(seen.esr), seen.ovl);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_esr_averaging_calculator: FAIL");
      $finish;
    end
  end

  initial begin
    logic [ADC_W-1:0] level;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct = 69;
    run_directed();
    drain_readings();

    level = $urandom_range(100, 1023);
    write_open_level(level);
    run_random(21, 69, 0, 1'b1);
    drain_readings();

    level = $urandom_range(900, 1023);
    write_open_level(level);
    run_random(69, 21, 0, 1'b0);
    drain_readings();

    // stall the output long enough to back up the job queue
    level = $urandom_range(0, 1023);
    write_open_level(level);
    run_random(0, 0, 800, 1'b0);
    drain_readings();

    if (pending_readings.size() != 0) begin
      mismatches += pending_readings.size();
      $display("%0d readings never arrived", pending_readings.size());
    end
    if (mismatches == 0) begin
      $display("tb_esr_averaging_calculator: PASS");
    end else begin
      $display("tb_esr_averaging_calculator: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
